/* rtl/adlr_pkg.sv */
`default_nettype none

package adlr_pkg;

    localparam int LANES = 8;
    localparam int DATA_BYTES_MAX = 8;
    localparam int LANE_COUNT = (LANES < DATA_BYTES_MAX) ? LANES : DATA_BYTES_MAX;

    localparam int COUNT_W = 4;
    localparam int WPROD_W = 12;
    localparam int SUMB_W = 11;
    localparam int SUMW_W = 14;
    localparam int HRAW_W = 20;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] SUM_MASK = 16'hffff;
    localparam logic [31:0] SEED_RESET = 32'd1;

    typedef struct packed {
        logic [7:0]         byte_val;
        logic [WPROD_W-1:0] weighted;
    } lane_out_t;

    typedef struct packed {
        logic [SUMB_W-1:0] sum_b;
        logic [SUMW_W-1:0] sum_w;
    } merge_out_t;

    // Final correction for a value known to be below twice the modulus.
    function automatic logic [15:0] mod_sub(input logic [16:0] x);
        logic [16:0] r;
        begin
            r = (x >= ADLER_MOD) ? (x - ADLER_MOD) : x;
            mod_sub = r[15:0] & SUM_MASK;
        end
    endfunction

    // 2^16 is 15 modulo 65521, so the upper bits fold back with weight 15.
    function automatic logic [15:0] mod_fold(input logic [HRAW_W-1:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x[15:0]} + 17'(x[HRAW_W-1:16]) * 17'd15;
            mod_fold = mod_sub(t);
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/adler32_stream_checksum_unit.sv */
`default_nettype none

// Streaming Adler-32 checksum unit.
// Input channel: item_valid/item_stall carry data_bytes (byte 0 in bits 7:0 first),
// byte_count (values above eight are taken as eight) and last_of_message.
// Output channel: result_valid/result_stall carry checksum, one transaction per
// message, produced by the transaction marked last_of_message.
// The seed register is written through cfg_wr_en/cfg_wr_data and is loaded into the
// running sums when a message starts; write it only while the unit is idle.
// Throughput is one input transaction per cycle while no last transaction waits
// on a stalled receiver. Eight byte lanes weight their bytes in parallel, and a
// merge tree feeds one registered accumulate step that closes the loop on the
// running sums. Accepted transactions are registered in the input stage; a last
// one writes its checksum to the output register as it advances. While the
// receiver stalls, the result holds there and transactions that do not end a
// message keep flowing; a last one waits in the input stage with item_stall high.
// Reset sets the seed to 1, clears both valid flags and arms a new message.

module adler32_stream_checksum_unit
    import adlr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [63:0]        data_bytes,
    input  wire logic [COUNT_W-1:0] byte_count,
    input  wire logic               last_of_message,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [31:0]             checksum
);

    logic [31:0]        seed_reg, seed_next;
    logic               a_valid_reg, a_valid_next;
    logic               at_start_reg, at_start_next;
    logic               result_valid_reg, result_valid_next;
    logic [COUNT_W-1:0] a_count_reg;
    logic [SUMB_W-1:0]  a_sumb_reg;
    logic [SUMW_W-1:0]  a_sumw_reg;
    logic               a_last_reg;
    logic [15:0]        low_reg, high_reg;
    logic [31:0]        checksum_reg;

    logic [COUNT_W-1:0] count_sat;
    lane_out_t          lane_res [LANE_COUNT];
    merge_out_t         merged;
    logic               accept, out_free, a_adv;
    logic [15:0]        base_low, base_high, low_new, high_new;
    logic [16:0]        low_raw;
    logic [HRAW_W-1:0]  high_raw;

    assign count_sat = (byte_count > COUNT_W'(LANE_COUNT)) ? COUNT_W'(LANE_COUNT) : byte_count;

    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        adlr_lane u_lane (
            .byte_in  (data_bytes[8*g +: 8]),
            .lane_idx (COUNT_W'(g)),
            .count    (count_sat),
            .result   (lane_res[g])
        );
    end

    adlr_merge u_merge (
        .lanes (lane_res),
        .sums  (merged)
    );

    assign out_free   = !result_valid_reg || !result_stall;
    assign a_adv      = a_valid_reg && (!a_last_reg || out_free);
    assign item_stall = a_valid_reg && !a_adv;
    assign accept     = item_valid && !item_stall;

    assign base_low  = at_start_reg ? seed_reg[15:0] : low_reg;
    assign base_high = at_start_reg ? seed_reg[31:16] : high_reg;

    assign low_raw  = {1'b0, base_low} + 17'(a_sumb_reg);
    assign high_raw = HRAW_W'(base_high) + HRAW_W'(a_count_reg) * HRAW_W'(base_low)
                      + HRAW_W'(a_sumw_reg);

    // With no bytes the sums stay exactly as they were, even if not reduced.
    assign low_new  = (a_count_reg == '0) ? base_low : mod_sub(low_raw);
    assign high_new = (a_count_reg == '0) ? base_high : mod_fold(high_raw);

    always_comb
    begin
        seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;

        if (accept)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        at_start_next = a_adv ? a_last_reg : at_start_reg;

        if (a_adv && a_last_reg)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg         <= SEED_RESET;
            a_valid_reg      <= 1'b0;
            at_start_reg     <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg         <= seed_next;
            a_valid_reg      <= a_valid_next;
            at_start_reg     <= at_start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_count_reg <= count_sat;
            a_sumb_reg  <= merged.sum_b;
            a_sumw_reg  <= merged.sum_w;
            a_last_reg  <= last_of_message;
        end
        if (a_adv)
        begin
            low_reg  <= low_new;
            high_reg <= high_new;
        end
        if (a_adv && a_last_reg)
            checksum_reg <= {high_new, low_new};
    end

    assign result_valid = result_valid_reg;
    assign checksum     = checksum_reg;

endmodule

`default_nettype wire

/* rtl/adlr_lane.sv */
`default_nettype none

module adlr_lane
    import adlr_pkg::*;
(
    input  wire logic [7:0]         byte_in,
    input  wire logic [COUNT_W-1:0] lane_idx,
    input  wire logic [COUNT_W-1:0] count,
    output lane_out_t               result
);

    logic               active;
    logic [COUNT_W-1:0] weight;
    logic [7:0]         masked;

    // A byte at position i feeds the high sum in count - i of the item's steps.
    assign active = (lane_idx < count);
    assign weight = active ? (count - lane_idx) : '0;
    assign masked = active ? byte_in : 8'd0;

    assign result.byte_val = masked;
    assign result.weighted = WPROD_W'(weight) * WPROD_W'(masked);

endmodule

`default_nettype wire

/* rtl/adlr_merge.sv */
`default_nettype none

module adlr_merge
    import adlr_pkg::*;
(
    input  wire lane_out_t lanes [LANE_COUNT],
    output merge_out_t     sums
);

    always_comb
    begin
        sums.sum_b = '0;
        sums.sum_w = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            sums.sum_b = sums.sum_b + SUMB_W'(lanes[i].byte_val);
            sums.sum_w = sums.sum_w + SUMW_W'(lanes[i].weighted);
        end
    end

endmodule

`default_nettype wire
